### rtl/pcc3_pkg.sv
// ----------------------------------------------------------------------------
// pcc3_pkg
// Shared types, constants and the charge table for the three-charge pipeline.
// ----------------------------------------------------------------------------
package pcc3_pkg;

    localparam int CODE_W = 32;
    localparam int MAG_W  = 24;   // magnitudes of interest stay below ten million
    localparam int CHG_W  = 4;

    localparam logic [CODE_W-1:0] MAG_LIMIT = 32'd10000000;

    // Reciprocals for division by constants (exact over the magnitude range)
    localparam logic [31:0] RECIP_10   = 32'hCCCCCCCD;   // >> 35
    localparam logic [31:0] RECIP_100  = 32'h51EB851F;   // >> 37
    localparam logic [31:0] RECIP_1000 = 32'h10624DD3;   // >> 38
    localparam logic [15:0] RECIP_10_S = 16'hCCCD;       // >> 19, 16-bit operand

    localparam logic [MAG_W-1:0] EXC_Z0 = 24'd1000017;
    localparam logic [MAG_W-1:0] EXC_Z1 = 24'd1000018;
    localparam logic [MAG_W-1:0] EXC_Z2 = 24'd1000034;
    localparam logic [MAG_W-1:0] EXC_Z3 = 24'd1000052;
    localparam logic [MAG_W-1:0] EXC_Z4 = 24'd1000053;
    localparam logic [MAG_W-1:0] EXC_Z5 = 24'd1000054;
    localparam logic [MAG_W-1:0] EXC_S0 = 24'd5100061;
    localparam logic [MAG_W-1:0] EXC_S1 = 24'd5100062;

    localparam logic signed [CHG_W-1:0] CHG_SIX = 4'sd6;

    typedef struct packed {
        logic neg;    // code was negative
        logic zero;   // zero code or eight digits and more
        logic exc0;   // listed code forced to charge 0
        logic exc6;   // listed code forced to charge 6
    } pcc3_flags_t;

    // Three-charge of a fundamental index (1..100); index 0 gives 0
    function automatic logic signed [CHG_W-1:0] tab_charge(input logic [6:0] idx);
        logic signed [CHG_W-1:0] c;
        case (idx)
            7'd1, 7'd3, 7'd5, 7'd7:       c = -4'sd1;
            7'd2, 7'd4, 7'd6, 7'd8:       c = 4'sd2;
            7'd11, 7'd13, 7'd15, 7'd17:   c = -4'sd3;
            7'd24, 7'd34, 7'd37, 7'd53:   c = 4'sd3;
            7'd42:                        c = -4'sd1;
            7'd52, 7'd54:                 c = 4'sd6;
            default:                      c = 4'sd0;
        endcase
        return c;
    endfunction

endpackage

### rtl/pcc3_digits.sv
// ----------------------------------------------------------------------------
// pcc3_digits
// Two-stage decimal digit extraction by reciprocal multiplication.
// ----------------------------------------------------------------------------
module pcc3_digits
    import pcc3_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              up_valid,
    output logic              up_ready,
    input  logic [MAG_W-1:0]  up_mag,
    input  pcc3_flags_t       up_flags,
    output logic              dn_valid,
    input  logic              dn_ready,
    output logic [3:0]        nj,
    output logic [3:0]        q3,
    output logic [3:0]        q2,
    output logic [13:0]       q1000,
    output logic [9:0]        q10000,
    output pcc3_flags_t       dn_flags
);

    logic en2;
    logic en3;

    // stage 2: quotients by 10, 100, 1000
    logic              v2_reg;
    logic [MAG_W-1:0]  mag2_reg;
    logic [19:0]       q10_reg;
    logic [16:0]       q100_reg;
    logic [13:0]       q1000_2_reg;
    pcc3_flags_t       flags2_reg;

    logic [55:0]       prod10;
    logic [55:0]       prod100;
    logic [55:0]       prod1000;
    logic              exc0_hit;
    logic              exc6_hit;
    pcc3_flags_t       flags2_next;

    // stage 3: low digits and quotient by 10000
    logic              v3_reg;
    logic [3:0]        nj_reg;
    logic [3:0]        q3_reg;
    logic [3:0]        q2_reg;
    logic [13:0]       q1000_3_reg;
    logic [9:0]        q10000_reg;
    pcc3_flags_t       flags3_reg;

    logic [MAG_W-1:0]  nj_full;
    logic [19:0]       q3_full;
    logic [16:0]       q2_full;
    logic [29:0]       prod10000;

    assign en3      = !v3_reg || dn_ready;
    assign en2      = !v2_reg || en3;
    assign up_ready = en2;

    assign prod10   = 56'(up_mag) * 56'(RECIP_10);
    assign prod100  = 56'(up_mag) * 56'(RECIP_100);
    assign prod1000 = 56'(up_mag) * 56'(RECIP_1000);

    assign exc0_hit = (up_mag == EXC_Z0) || (up_mag == EXC_Z1) || (up_mag == EXC_Z2) ||
                      (up_mag == EXC_Z3) || (up_mag == EXC_Z4) || (up_mag == EXC_Z5);
    assign exc6_hit = (up_mag == EXC_S0) || (up_mag == EXC_S1);

    always_comb
    begin
        flags2_next      = up_flags;
        flags2_next.exc0 = exc0_hit;
        flags2_next.exc6 = exc6_hit;
    end

    // remainder = value - 10 * quotient, written as shifts
    assign nj_full   = mag2_reg - (24'({q10_reg, 3'b000}) + 24'({q10_reg, 1'b0}));
    assign q3_full   = q10_reg - (20'({q100_reg, 3'b000}) + 20'({q100_reg, 1'b0}));
    assign q2_full   = q100_reg - (17'({q1000_2_reg, 3'b000}) + 17'({q1000_2_reg, 1'b0}));
    assign prod10000 = 30'(q1000_2_reg) * 30'(RECIP_10_S);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (en2)
            begin
                v2_reg <= up_valid;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en2 && up_valid)
        begin
            mag2_reg    <= up_mag;
            q10_reg     <= prod10[35 +: 20];
            q100_reg    <= prod100[37 +: 17];
            q1000_2_reg <= prod1000[38 +: 14];
            flags2_reg  <= flags2_next;
        end
        if (en3 && v2_reg)
        begin
            nj_reg      <= nj_full[3:0];
            q3_reg      <= q3_full[3:0];
            q2_reg      <= q2_full[3:0];
            q1000_3_reg <= q1000_2_reg;
            q10000_reg  <= prod10000[19 +: 10];
            flags3_reg  <= flags2_reg;
        end
    end

    assign dn_valid = v3_reg;
    assign nj       = nj_reg;
    assign q3       = q3_reg;
    assign q2       = q2_reg;
    assign q1000    = q1000_3_reg;
    assign q10000   = q10000_reg;
    assign dn_flags = flags3_reg;

endmodule

### rtl/particle_code_three_charge_core.sv
// ----------------------------------------------------------------------------
// particle_code_three_charge_core
// Three times the electric charge of a signed particle numbering-scheme code.
// Throughput: one request per cycle while charge_stall stays low; five register
// stages (magnitude, divide, digits, lookup, combine), each holding its own
// valid bit.
// Reset: asynchronous, active low; clears the valid bits only, no init pass.
// ----------------------------------------------------------------------------
module particle_code_three_charge_core
    import pcc3_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     code_valid,
    output logic                     code_stall,
    input  logic signed [CODE_W-1:0] particle_code,
    output logic                     charge_valid,
    input  logic                     charge_stall,
    output logic signed [CHG_W-1:0]  three_charge
);

    logic en1;
    logic en4;
    logic en5;
    logic sub_ready;

    // stage 1: magnitude and range
    logic              v1_reg;
    logic [MAG_W-1:0]  mag1_reg;
    pcc3_flags_t       flags1_reg;
    logic [CODE_W-1:0] mag_full;
    pcc3_flags_t       flags1_next;

    // digit extraction
    logic              v3;
    logic [3:0]        nj3;
    logic [3:0]        q3_3;
    logic [3:0]        q2_3;
    logic [13:0]       q1000_3;
    logic [9:0]        q10000_3;
    pcc3_flags_t       flags3;

    // stage 4: last digit and lookups
    logic                    v4_reg;
    logic [3:0]              nj4_reg;
    logic [3:0]              q3_4_reg;
    logic [3:0]              q2_4_reg;
    logic [3:0]              q1_4_reg;
    logic signed [CHG_W-1:0] fund_reg;
    logic signed [CHG_W-1:0] c3_reg;
    logic signed [CHG_W-1:0] c2_reg;
    pcc3_flags_t             flags4_reg;
    logic [13:0]             q1_full;
    logic [6:0]              fid;

    // stage 5: combine
    logic                    v5_reg;
    logic signed [CHG_W-1:0] charge_reg;
    logic signed [CHG_W-1:0] charge_next;
    logic signed [CHG_W-1:0] c1;
    logic signed [CHG_W-1:0] ch;

    assign en5        = !v5_reg || !charge_stall;
    assign en4        = !v4_reg || en5;
    assign en1        = !v1_reg || sub_ready;
    assign code_stall = !en1;

    assign mag_full = particle_code[CODE_W-1] ? (~particle_code + 32'd1) : particle_code;

    always_comb
    begin
        flags1_next      = '0;
        flags1_next.neg  = particle_code[CODE_W-1];
        flags1_next.zero = (mag_full == '0) || (mag_full >= MAG_LIMIT);
    end

    pcc3_digits u_digits (
        .clk      (clk),
        .rst_n    (rst_n),
        .up_valid (v1_reg),
        .up_ready (sub_ready),
        .up_mag   (mag1_reg),
        .up_flags (flags1_reg),
        .dn_valid (v3),
        .dn_ready (en4),
        .nj       (nj3),
        .q3       (q3_3),
        .q2       (q2_3),
        .q1000    (q1000_3),
        .q10000   (q10000_3),
        .dn_flags (flags3)
    );

    assign q1_full = q1000_3 - (14'({q10000_3, 3'b000}) + 14'({q10000_3, 1'b0}));
    assign fid     = 7'({q3_3, 3'b000}) + 7'({q3_3, 1'b0}) + 7'(nj3);

    assign c1 = tab_charge(7'(q1_4_reg));

    always_comb
    begin
        if (q1_4_reg == 4'd0 && q2_4_reg == 4'd0)
        begin
            // fundamental particle: low two digits index the table
            if (flags4_reg.exc0)
                ch = '0;
            else if (flags4_reg.exc6)
                ch = CHG_SIX;
            else
                ch = fund_reg;
        end
        else if (nj4_reg == 4'd0)
        begin
            ch = '0;
        end
        else if (q1_4_reg == 4'd0)
        begin
            // meson; down-type heavier quark flips the order
            if (q2_4_reg == 4'd3 || q2_4_reg == 4'd5)
                ch = c3_reg - c2_reg;
            else
                ch = c2_reg - c3_reg;
        end
        else if (q3_4_reg == 4'd0)
        begin
            ch = c2_reg + c1;
        end
        else
        begin
            ch = c3_reg + c2_reg + c1;
        end

        if (flags4_reg.zero)
            charge_next = '0;
        else if (flags4_reg.neg)
            charge_next = -ch;
        else
            charge_next = ch;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= code_valid;
            end
            if (en4)
            begin
                v4_reg <= v3;
            end
            if (en5)
            begin
                v5_reg <= v4_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1 && code_valid)
        begin
            mag1_reg   <= mag_full[MAG_W-1:0];
            flags1_reg <= flags1_next;
        end
        if (en4 && v3)
        begin
            nj4_reg    <= nj3;
            q3_4_reg   <= q3_3;
            q2_4_reg   <= q2_3;
            q1_4_reg   <= q1_full[3:0];
            fund_reg   <= tab_charge(fid);
            c3_reg     <= tab_charge(7'(q3_3));
            c2_reg     <= tab_charge(7'(q2_3));
            flags4_reg <= flags3;
        end
        if (en5 && v4_reg)
        begin
            charge_reg <= charge_next;
        end
    end

    assign charge_valid = v5_reg;
    assign three_charge = charge_reg;

`ifndef SYNTHESIS
    // an empty output stage means the whole pipeline can move
    assert property (@(posedge clk) disable iff (!rst_n) !charge_valid |-> !code_stall)
        else $error("request stalled with empty output stage");

    assert property (@(posedge clk) disable iff (!rst_n)
        charge_valid |-> (three_charge != -4'sd8 && three_charge != -4'sd7 &&
                          three_charge != 4'sd7))
        else $error("three_charge out of range");

    // a held lookup stage keeps its item
    assert property (@(posedge clk) disable iff (!rst_n) v4_reg && !en4 |=> v4_reg)
        else $error("lookup stage dropped an item");
`endif

endmodule

### verif/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives signed particle codes into the three-charge pipeline and checks each
// returned charge in order. A short table of hand-picked codes runs first,
// followed by random codes biased towards well-formed hadron and lepton
// codes. The sender runs in bursts with gaps, and the receiver stalls in
// changing patterns.
// ----------------------------------------------------------------------------
module testbench
    import pcc3_pkg::*;
();

    localparam int RANDOM_CODES = 1750;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 12;

    localparam int unsigned DIGIT_LIMIT = 10000000;
    localparam int unsigned ZERO_EXC_A  = 1000017;
    localparam int unsigned ZERO_EXC_B  = 1000018;
    localparam int unsigned ZERO_EXC_C  = 1000034;
    localparam int unsigned ZERO_EXC_D  = 1000052;
    localparam int unsigned ZERO_EXC_E  = 1000053;
    localparam int unsigned ZERO_EXC_F  = 1000054;
    localparam int unsigned SIX_EXC_A   = 5100061;
    localparam int unsigned SIX_EXC_B   = 5100062;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_RANDOM,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct packed {
        logic signed [CODE_W-1:0] code;
        logic signed [CHG_W-1:0]  charge;
    } charge_req_t;

    typedef struct {
        logic signed [CODE_W-1:0] code;
        bit                       typed;
        logic signed [CHG_W-1:0]  charge;
    } code_vector_t;

    logic                     clk;
    logic                     rst_n;
    logic                     code_valid;
    logic                     code_stall;
    logic signed [CODE_W-1:0] particle_code;
    logic                     charge_valid;
    logic                     charge_stall;
    logic signed [CHG_W-1:0]  three_charge;

    charge_req_t  pending_charges[$];
    code_vector_t directed_codes[$];
    int           err_count;
    int           burst_left;

    particle_code_three_charge_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .code_valid    (code_valid),
        .code_stall    (code_stall),
        .particle_code (particle_code),
        .charge_valid  (charge_valid),
        .charge_stall  (charge_stall),
        .three_charge  (three_charge)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Three-charge of a fundamental id; also used for single quark digits
    function automatic int id_charge(input int unsigned id);
        case (id)
            1, 3, 5, 7, 42:     return -1;
            2, 4, 6, 8:         return 2;
            11, 13, 15, 17:     return -3;
            24, 34, 37, 53:     return 3;
            52, 54:             return 6;
            default:            return 0;
        endcase
    endfunction

    function automatic logic signed [CHG_W-1:0] predict_three_charge(
        input logic signed [CODE_W-1:0] code);
        logic [CODE_W-1:0] mag;
        int unsigned       units, tens, hundreds, thousands, fund_id;
        int                sum;
        mag = code[CODE_W-1] ? (~code + 1'b1) : code;
        if (mag == 0 || mag >= DIGIT_LIMIT)
            return '0;
        units     = mag % 10;
        tens      = (mag / 10) % 10;
        hundreds  = (mag / 100) % 10;
        thousands = (mag / 1000) % 10;
        if (hundreds == 0 && thousands == 0)
            fund_id = mag % 10000;
        else if (mag <= 102)
            fund_id = mag;
        else
            fund_id = 0;

        if (fund_id > 0 && fund_id <= 100)
        begin
            sum = id_charge(fund_id);
            if (mag == ZERO_EXC_A || mag == ZERO_EXC_B || mag == ZERO_EXC_C ||
                mag == ZERO_EXC_D || mag == ZERO_EXC_E || mag == ZERO_EXC_F)
                sum = 0;
            if (mag == SIX_EXC_A || mag == SIX_EXC_B)
                sum = 6;
        end
        else if (units == 0)
            sum = 0;
        else if (thousands == 0)
        begin
            // mesons: the heavier antiquark sits in the hundreds digit for s and b
            if (hundreds == 3 || hundreds == 5)
                sum = id_charge(tens) - id_charge(hundreds);
            else
                sum = id_charge(hundreds) - id_charge(tens);
        end
        else if (tens == 0)
            sum = id_charge(hundreds) + id_charge(thousands);
        else
            sum = id_charge(tens) + id_charge(hundreds) + id_charge(thousands);

        if (code[CODE_W-1])
            sum = -sum;
        return sum[CHG_W-1:0];
    endfunction

    function automatic logic signed [CODE_W-1:0] random_code();
        int unsigned pick;
        int unsigned mag;
        pick = $urandom_range(0, 99);
        if (pick < 15)
            return $urandom;
        if (pick < 27)
            mag = $urandom_range(0, 120);
        else if (pick < 33)
        begin
            case ($urandom_range(0, 7))
                0:       mag = ZERO_EXC_A;
                1:       mag = ZERO_EXC_B;
                2:       mag = ZERO_EXC_C;
                3:       mag = ZERO_EXC_D;
                4:       mag = ZERO_EXC_E;
                5:       mag = ZERO_EXC_F;
                6:       mag = SIX_EXC_A;
                default: mag = SIX_EXC_B;
            endcase
            mag = mag + $urandom_range(0, 2) - 1;
        end
        else if (pick < 75)
            // well-formed hadron-like code: random digits, mostly short prefixes
            mag = $urandom_range(0, 9) * 1000 + $urandom_range(0, 9) * 100
                + $urandom_range(0, 9) * 10 + $urandom_range(0, 9)
                + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 999) * 10000 : 0);
        else if (pick < 80)
            mag = DIGIT_LIMIT + $urandom_range(0, 4) - 2;
        else
            mag = $urandom_range(0, DIGIT_LIMIT - 1);
        return $urandom_range(0, 1) ? -$signed(mag) : $signed(mag);
    endfunction

    task automatic report_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("%0t: %s", $time, msg);
    endtask

    task automatic add_vector(input logic signed [CODE_W-1:0] code, input bit typed,
                              input logic signed [CHG_W-1:0] charge);
        code_vector_t v;
        v.code   = code;
        v.typed  = typed;
        v.charge = charge;
        directed_codes.insert(directed_codes.size(), v);
    endtask

    // Entered and left at a falling edge
    task automatic send_code(input logic signed [CODE_W-1:0] code,
                             input logic signed [CHG_W-1:0] charge);
        charge_req_t req;
        int          gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
            if (gap != 0)
            begin
                code_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        code_valid    <= 1'b1;
        particle_code <= code;
        do
            @(posedge clk);
        while (code_stall);
        req.code   = code;
        req.charge = charge;
        pending_charges.insert(pending_charges.size(), req);
        burst_left--;
        @(negedge clk);
    endtask

    // Receiver stall patterns, each held for a random stretch
    initial
    begin
        stall_mode_t mode;
        int          mode_left;
        int          phase;
        mode      = STALL_NONE;
        mode_left = 0;
        phase     = 0;
        charge_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (mode_left == 0)
            begin
                mode      = stall_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
            end
            case (mode)
                STALL_NONE:     charge_stall <= 1'b0;
                STALL_RANDOM:   charge_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:    charge_stall <= ($urandom_range(0, 3) != 0);
                STALL_PERIODIC: charge_stall <= (phase % 5 < 2);
                default:        charge_stall <= 1'b0;
            endcase
            phase++;
            mode_left--;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && charge_valid && !charge_stall)
        begin
            if (pending_charges.size() == 0)
                report_error($sformatf("unexpected charge %0d", three_charge));
            else
            begin
                if (three_charge !== pending_charges[0].charge)
                    report_error($sformatf("code %0d: charge expected %0d, got %0d",
                                           pending_charges[0].code,
                                           pending_charges[0].charge, three_charge));
                void'(pending_charges.pop_front());
            end
        end
    end

    initial
    begin
        #1000000;
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic signed [CODE_W-1:0] code;
        err_count     = 0;
        burst_left    = 0;
        rst_n         = 1'b0;
        code_valid    = 1'b0;
        particle_code = '0;

        add_vector(32'sd0,            1, 4'sd0);
        add_vector(-32'sd2147483648,  1, 4'sd0);
        add_vector(32'sd2147483647,   1, 4'sd0);
        add_vector(32'sd10000000,     1, 4'sd0);
        add_vector(32'sd9999999,      0, 4'sd0);
        add_vector(32'sd1,            1, -4'sd1);
        add_vector(-32'sd1,           1, 4'sd1);
        add_vector(32'sd11,           1, -4'sd3);
        add_vector(-32'sd11,          1, 4'sd3);
        add_vector(32'sd24,           1, 4'sd3);
        add_vector(32'sd100,          0, 4'sd0);
        add_vector(32'sd101,          0, 4'sd0);
        add_vector(-32'sd102,         0, 4'sd0);
        add_vector(32'sd1000017,      1, 4'sd0);
        add_vector(32'sd1000052,      1, 4'sd0);
        add_vector(32'sd1000024,      0, 4'sd0);
        add_vector(32'sd5100061,      1, 4'sd6);
        add_vector(-32'sd5100062,     1, -4'sd6);
        add_vector(32'sd211,          1, 4'sd3);
        add_vector(-32'sd321,         0, 4'sd0);
        add_vector(32'sd2212,         1, 4'sd3);
        add_vector(-32'sd2224,        1, -4'sd6);
        add_vector(32'sd1103,         0, 4'sd0);
        add_vector(32'sd3122,         0, 4'sd0);
        add_vector(32'sd110,          1, 4'sd0);

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_codes[i])
            send_code(directed_codes[i].code,
                      directed_codes[i].typed ? directed_codes[i].charge
                                              : predict_three_charge(directed_codes[i].code));

        repeat (RANDOM_CODES)
        begin
            code = random_code();
            send_code(code, predict_three_charge(code));
        end
        code_valid <= 1'b0;

        while (pending_charges.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (err_count == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule
